/* hdl/fec_pkg.sv */
`timescale 1ns / 1ps

package fec_pkg;

  // Grid geometry.
  localparam int GRID_WIDTH  = 512;
  localparam int GRID_HEIGHT = 64;
  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
  localparam int COL_W       = $clog2(GRID_WIDTH);
  localparam int ROW_W       = $clog2(GRID_HEIGHT);
  localparam int ADDR_W      = $clog2(CELL_COUNT);

  // Heat levels.
  localparam int HEAT_W = 6;
  localparam logic [HEAT_W-1:0] HEAT_MAX = 6'd36;

  // Command codes.
  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  typedef struct packed {
    logic       command;
    logic [1:0] decay;
    logic [5:0] read_row;
    logic [8:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  out_row;
    logic [8:0]  out_col;
    logic [5:0]  heat;
    logic [23:0] rgb;
    logic        frame_done;
  } out_item_t;

  // Linear cell address of (row, col).
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    int lin;
    lin = int'(row) * GRID_WIDTH + int'(col);
    return ADDR_W'(lin);
  endfunction

  // Fixed fire palette, red in the top byte.
  function automatic logic [23:0] palette(input logic [HEAT_W-1:0] h);
    logic [23:0] c;
    case (h)
      6'd0:    c = 24'h070707;
      6'd1:    c = 24'h1f0707;
      6'd2:    c = 24'h2f0f07;
      6'd3:    c = 24'h470f07;
      6'd4:    c = 24'h571707;
      6'd5:    c = 24'h671f07;
      6'd6:    c = 24'h771f07;
      6'd7:    c = 24'h8f2707;
      6'd8:    c = 24'h9f2f07;
      6'd9:    c = 24'haf3f07;
      6'd10:   c = 24'hbf4707;
      6'd11:   c = 24'hc74707;
      6'd12:   c = 24'hdf4f07;
      6'd13:   c = 24'hdf5707;
      6'd14:   c = 24'hdf5707;
      6'd15:   c = 24'hd75f07;
      6'd16:   c = 24'hd75f07;
      6'd17:   c = 24'hd7670f;
      6'd18:   c = 24'hcf6f0f;
      6'd19:   c = 24'hcf770f;
      6'd20:   c = 24'hcf7f0f;
      6'd21:   c = 24'hcf8717;
      6'd22:   c = 24'hc78717;
      6'd23:   c = 24'hc78f17;
      6'd24:   c = 24'hc7971f;
      6'd25:   c = 24'hbf9f1f;
      6'd26:   c = 24'hbf9f1f;
      6'd27:   c = 24'hbfa727;
      6'd28:   c = 24'hbfa727;
      6'd29:   c = 24'hbfaf2f;
      6'd30:   c = 24'hb7af2f;
      6'd31:   c = 24'hb7b72f;
      6'd32:   c = 24'hb7b737;
      6'd33:   c = 24'hcfcf6f;
      6'd34:   c = 24'hdfdf9f;
      6'd35:   c = 24'hefefc7;
      default: c = 24'hffffff;
    endcase
    return c;
  endfunction

endpackage

/* hdl/fec_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module fec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/fire_effect_cell_updater.sv */
`timescale 1ns / 1ps

// Fire effect cell updater: a grid of heat levels (0..36) swept one cell per
// advance command, with a read command that returns a cell and its color.
// Input channel: start with in_data; a beat is taken at a clock edge where
// start is high and busy is low. Command advance updates the next cell of the
// raster sweep over every row but the bottom; command read looks up one cell.
// Result channel: out_valid is high for exactly one cycle with out_data; the
// receiver cannot stall, so every result must be taken in that cycle.
// The command and the heat RAM read are registered at the accepting edge; the
// result is computed and registered in ST_CALC, with the advance write-back.
// busy is high in ST_CALC, so a command is taken only once the last is done.
// Reset: rst_n is synchronous, active low. After reset a clearing pass writes
// heat 36 to every cell, one cell per cycle, all 32768 cells of the 512 x 64
// grid; busy stays high until it ends. The sweep restarts at row 0, column 0.
module fire_effect_cell_updater (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fec_pkg::in_item_t   in_data,
  output logic                out_valid,
  output fec_pkg::out_item_t  out_data
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;

  localparam int ROW_W  = fec_pkg::ROW_W;
  localparam int COL_W  = fec_pkg::COL_W;
  localparam int ADDR_W = fec_pkg::ADDR_W;
  localparam int HEAT_W = fec_pkg::HEAT_W;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [ROW_W-1:0]  sweep_row_r, sweep_row_nxt;
  logic [COL_W-1:0]  sweep_col_r, sweep_col_nxt;

  // Command captured at the accepting edge.
  logic              cmd_r;
  logic [1:0]        decay_r;
  logic [5:0]        rd_row_r;
  logic [8:0]        rd_col_r;
  logic              rd_ok_r;

  logic               out_valid_r, out_valid_nxt;
  fec_pkg::out_item_t out_data_r, out_data_nxt;

  logic              accept;
  logic              rd_ok;
  logic [ADDR_W-1:0] rd_addr;
  logic [HEAT_W-1:0] ram_q;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [HEAT_W-1:0] wr_data;

  logic [COL_W:0]    dst_sum;
  logic [COL_W-1:0]  dst_col;
  logic [HEAT_W-1:0] new_heat;
  logic [HEAT_W-1:0] rd_heat;
  logic              last_col;
  logic              last_row;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Read address is issued straight from the accepted beat.
  assign rd_ok = ({1'b0, in_data.read_row} < 7'(fec_pkg::GRID_HEIGHT)) &&
                 ({2'b0, in_data.read_col} < 11'(fec_pkg::GRID_WIDTH));

  always_comb begin
    if (in_data.command == fec_pkg::CMD_READ) begin
      rd_addr = fec_pkg::cell_addr(ROW_W'(in_data.read_row), COL_W'(in_data.read_col));
    end else begin
      rd_addr = fec_pkg::cell_addr(sweep_row_r + ROW_W'(1), sweep_col_r);
    end
  end

  // Decay with clamp at zero, and destination column wrapped within the row.
  assign new_heat = (ram_q > HEAT_W'(decay_r)) ? (ram_q - HEAT_W'(decay_r)) : '0;
  assign dst_sum  = {1'b0, sweep_col_r} + (COL_W + 1)'(decay_r);
  assign dst_col  = (dst_sum >= (COL_W + 1)'(fec_pkg::GRID_WIDTH)) ?
                    COL_W'(dst_sum - (COL_W + 1)'(fec_pkg::GRID_WIDTH)) :
                    COL_W'(dst_sum);
  assign rd_heat  = rd_ok_r ? ram_q : '0;
  assign last_col = (sweep_col_r == COL_W'(fec_pkg::GRID_WIDTH - 1));
  assign last_row = (sweep_row_r == ROW_W'(fec_pkg::GRID_HEIGHT - 2));

  // Write port: clearing pass, or the updated cell of an advance.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr_r;
    wr_data = fec_pkg::HEAT_MAX;
    if (state_r == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (state_r == ST_CALC && cmd_r == fec_pkg::CMD_ADVANCE) begin
      wr_en   = 1'b1;
      wr_addr = fec_pkg::cell_addr(sweep_row_r, dst_col);
      wr_data = new_heat;
    end
  end

  fec_ram #(
    .WIDTH (HEAT_W),
    .DEPTH (fec_pkg::CELL_COUNT)
  ) u_heat_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Sequencer, sweep position and result register.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    sweep_row_nxt = sweep_row_r;
    sweep_col_nxt = sweep_col_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(fec_pkg::CELL_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        if (cmd_r == fec_pkg::CMD_READ) begin
          out_data_nxt.out_row    = rd_row_r;
          out_data_nxt.out_col    = rd_col_r;
          out_data_nxt.heat       = rd_heat;
          out_data_nxt.rgb        = fec_pkg::palette(rd_heat);
          out_data_nxt.frame_done = 1'b0;
        end else begin
          out_data_nxt.out_row    = 6'(sweep_row_r);
          out_data_nxt.out_col    = 9'(dst_col);
          out_data_nxt.heat       = new_heat;
          out_data_nxt.rgb        = fec_pkg::palette(new_heat);
          out_data_nxt.frame_done = last_col && last_row;
          if (last_col) begin
            sweep_col_nxt = '0;
            sweep_row_nxt = last_row ? '0 : sweep_row_r + ROW_W'(1);
          end else begin
            sweep_col_nxt = sweep_col_r + COL_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      sweep_row_r <= '0;
      sweep_col_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      sweep_row_r <= sweep_row_nxt;
      sweep_col_r <= sweep_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      cmd_r    <= in_data.command;
      decay_r  <= in_data.decay;
      rd_row_r <= in_data.read_row;
      rd_col_r <= in_data.read_col;
      rd_ok_r  <= rd_ok;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sim/fire_effect_cell_updater_tb.sv */
`timescale 1ns / 1ps

module fire_effect_cell_updater_tb;
  import fec_pkg::*;

  localparam int unsigned SWEEP_CELLS = (GRID_HEIGHT - 1) * GRID_WIDTH;
  localparam int unsigned RANDOM_BEATS = 1550;
  localparam int unsigned MAX_IDLE = 12;

  typedef struct {
    in_item_t    beat;
    int unsigned idle;
  } pending_beat_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;

  // Fire palette, one entry per heat level.
  logic [23:0] fire_colors [37] = '{
    24'h070707, 24'h1f0707, 24'h2f0f07, 24'h470f07,
    24'h571707, 24'h671f07, 24'h771f07, 24'h8f2707,
    24'h9f2f07, 24'haf3f07, 24'hbf4707, 24'hc74707,
    24'hdf4f07, 24'hdf5707, 24'hdf5707, 24'hd75f07,
    24'hd75f07, 24'hd7670f, 24'hcf6f0f, 24'hcf770f,
    24'hcf7f0f, 24'hcf8717, 24'hc78717, 24'hc78f17,
    24'hc7971f, 24'hbf9f1f, 24'hbf9f1f, 24'hbfa727,
    24'hbfa727, 24'hbfaf2f, 24'hb7af2f, 24'hb7b72f,
    24'hb7b737, 24'hcfcf6f, 24'hdfdf9f, 24'hefefc7,
    24'hffffff
  };

  // Shadow copy of the heat grid and the sweep position.
  logic [5:0]  heat_grid [CELL_COUNT];
  int unsigned sweep_r;
  int unsigned sweep_c;

  pending_beat_t pending_beats [$];
  out_item_t     expected_cells [$];
  int unsigned   advances_queued;
  int unsigned   error_count = 0;
  int unsigned   results_seen = 0;

  pending_beat_t cur_beat;
  logic          beat_loaded = 1'b0;
  int unsigned   idle_left = 0;

  fire_effect_cell_updater u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Next heat grid state and the result for one accepted beat.
  function automatic out_item_t fire_cell_update(input in_item_t beat);
    out_item_t   res;
    int unsigned r;
    int unsigned c;
    int unsigned h;
    int unsigned below;
    int unsigned dst;
    res = '0;
    if (beat.command == CMD_READ) begin
      h = 0;
      if (int'(beat.read_row) < GRID_HEIGHT && int'(beat.read_col) < GRID_WIDTH) begin
        h = heat_grid[int'(beat.read_row) * GRID_WIDTH + int'(beat.read_col)];
      end
      res.out_row = beat.read_row;
      res.out_col = beat.read_col;
      res.heat = 6'(h);
      res.rgb = fire_colors[h];
    end else begin
      r = sweep_r;
      c = sweep_c;
      below = heat_grid[(r + 1) * GRID_WIDTH + c];
      h = (below > beat.decay) ? below - beat.decay : 0;
      dst = (c + beat.decay) % GRID_WIDTH;
      heat_grid[r * GRID_WIDTH + dst] = 6'(h);
      res.out_row = 6'(r);
      res.out_col = 9'(dst);
      res.heat = 6'(h);
      res.rgb = fire_colors[h];
      // Step the raster sweep; wrapping past the last source row ends a frame.
      c++;
      if (c >= GRID_WIDTH) begin
        c = 0;
        r++;
        if (r > GRID_HEIGHT - 2) begin
          r = 0;
          res.frame_done = 1'b1;
        end
      end
      sweep_r = r;
      sweep_c = c;
    end
    return res;
  endfunction

  task automatic note_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got !== want) begin
      note_error($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                           results_seen, name, got, want));
    end
  endtask

  task automatic queue_beat(input logic cmd, input logic [1:0] decay,
                            input int unsigned row, input int unsigned col,
                            input int unsigned idle);
    pending_beat_t p;
    p.beat.command = cmd;
    p.beat.decay = decay;
    p.beat.read_row = 6'(row);
    p.beat.read_col = 9'(col);
    p.idle = idle;
    pending_beats.insert(pending_beats.size(), p);
    if (cmd == CMD_ADVANCE) begin
      advances_queued++;
    end
  endtask

  // One random beat: mostly advances, with reads aimed near the sweep front.
  task automatic queue_random_beat(input int unsigned idle);
    int unsigned pos;
    int unsigned row;
    int unsigned col;
    int unsigned pick;
    logic [1:0]  decay;
    pos = advances_queued % SWEEP_CELLS;
    row = pos / GRID_WIDTH;
    col = pos % GRID_WIDTH;
    pick = $urandom_range(0, 99);
    if (col >= GRID_WIDTH - 4) begin
      // Push the column shift past the end of the row.
      decay = 2'($urandom_range(1, 3));
    end else if ($urandom_range(0, 7) == 0) begin
      decay = 2'd3;
    end else begin
      decay = 2'($urandom_range(0, 2));
    end
    if (pick < 65) begin
      queue_beat(CMD_ADVANCE, decay, $urandom_range(0, 63), $urandom_range(0, 511), idle);
    end else if (pick < 85) begin
      row = row + $urandom_range(0, 1);
      col = (col + GRID_WIDTH + $urandom_range(0, 3) - $urandom_range(0, 6)) % GRID_WIDTH;
      queue_beat(CMD_READ, decay, row, col, idle);
    end else if (pick < 92) begin
      col = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3) : $urandom_range(508, 511);
      queue_beat(CMD_READ, decay, $urandom_range(0, 2), col, idle);
    end else begin
      queue_beat(CMD_READ, decay, $urandom_range(0, 63), $urandom_range(0, 511), idle);
    end
  endtask

  // Driver: present queued beats, holding each until the block takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      beat_loaded = 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        expected_cells.insert(expected_cells.size(), fire_cell_update(in_data));
      end
      if (!start || !busy) begin
        if (!beat_loaded && pending_beats.size() > 0) begin
          cur_beat = pending_beats.pop_front();
          idle_left = cur_beat.idle;
          beat_loaded = 1'b1;
        end
        if (beat_loaded && idle_left == 0) begin
          in_data <= cur_beat.beat;
          start <= 1'b1;
          beat_loaded = 1'b0;
        end else begin
          start <= 1'b0;
          if (beat_loaded) begin
            idle_left--;
          end
        end
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_cells.size() == 0) begin
        note_error($sformatf("unexpected result row %0d col %0d",
                             out_data.out_row, out_data.out_col));
      end else begin
        want = expected_cells.pop_front();
        check_field("out_row", out_data.out_row, want.out_row);
        check_field("out_col", out_data.out_col, want.out_col);
        check_field("heat", out_data.heat, want.heat);
        check_field("rgb", out_data.rgb, want.rgb);
        check_field("frame_done", out_data.frame_done, want.frame_done);
      end
      results_seen++;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic burst;
    for (int i = 0; i < CELL_COUNT; i++) begin
      heat_grid[i] = HEAT_MAX;
    end
    sweep_r = 0;
    sweep_c = 0;
    advances_queued = 0;
    burst = 1'b0;

    // Directed: reset contents, corners, every decay, then read back.
    queue_beat(CMD_READ, 2'd0, 0, 0, 0);
    queue_beat(CMD_READ, 2'd3, 63, 511, 0);
    queue_beat(CMD_READ, 2'd1, 63, 0, 5);
    queue_beat(CMD_READ, 2'd2, 31, 256, 12);
    queue_beat(CMD_ADVANCE, 2'd0, 63, 511, 0);
    queue_beat(CMD_ADVANCE, 2'd1, 0, 0, 0);
    queue_beat(CMD_ADVANCE, 2'd2, 42, 170, 3);
    queue_beat(CMD_ADVANCE, 2'd3, 21, 341, 0);
    for (int i = 0; i < 8; i++) begin
      queue_beat(CMD_READ, 2'(i), 0, i, i % 3);
    end
    queue_beat(CMD_READ, 2'd0, 1, 0, 1);
    queue_beat(CMD_ADVANCE, 2'd3, 0, 0, 0);
    queue_beat(CMD_ADVANCE, 2'd0, 0, 0, 7);
    queue_beat(CMD_READ, 2'd0, 0, 7, 0);
    queue_beat(CMD_READ, 2'd0, 0, 4, 0);

    // Random mix with bursts of back-to-back beats.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 64 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      queue_random_beat(burst ? 0 : $urandom_range(0, MAX_IDLE));
    end

    // Hold reset, then release it on a clock edge.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do begin
      @(posedge clk);
    end while (pending_beats.size() != 0 || beat_loaded || start ||
               expected_cells.size() != 0);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("fire_effect_cell_updater: match");
    end else begin
      $display("fire_effect_cell_updater: mismatch");
    end
    $finish;
  end

  // Watchdog covering the clearing pass and the slowest legal run.
  initial begin
    #3_000_000;
    $display("fire_effect_cell_updater: mismatch");
    $finish;
  end

endmodule

/* sim.f */
hdl/fec_pkg.sv
hdl/fec_ram.sv
hdl/fire_effect_cell_updater.sv
sim/fire_effect_cell_updater_tb.sv
